// ===== rtl/ptz_command_frame_builder_macros.svh =====
// Assertion shorthands used by the frame builder back end (ptzfb_back).
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef PTZ_COMMAND_FRAME_BUILDER_MACROS_SVH
`define PTZ_COMMAND_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication.
`define PTZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ptz frame builder assertion failed");

// Next-cycle implication.
`define PTZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ptz frame builder assertion failed");

`endif

// ===== rtl/ptzfb_pkg.sv =====
package ptzfb_pkg;

	localparam int CMD_W       = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request codes
	localparam logic [CMD_W-1:0] CMD_UP           = 5'd0;
	localparam logic [CMD_W-1:0] CMD_DOWN         = 5'd1;
	localparam logic [CMD_W-1:0] CMD_LEFT         = 5'd2;
	localparam logic [CMD_W-1:0] CMD_RIGHT        = 5'd3;
	localparam logic [CMD_W-1:0] CMD_LEFT_UP      = 5'd4;
	localparam logic [CMD_W-1:0] CMD_RIGHT_UP     = 5'd5;
	localparam logic [CMD_W-1:0] CMD_LEFT_DOWN    = 5'd6;
	localparam logic [CMD_W-1:0] CMD_RIGHT_DOWN   = 5'd7;
	localparam logic [CMD_W-1:0] CMD_AUTOPAN      = 5'd8;
	localparam logic [CMD_W-1:0] CMD_IRIS_OPEN    = 5'd9;
	localparam logic [CMD_W-1:0] CMD_IRIS_CLOSE   = 5'd10;
	localparam logic [CMD_W-1:0] CMD_ZOOM_IN      = 5'd11;
	localparam logic [CMD_W-1:0] CMD_ZOOM_OUT     = 5'd12;
	localparam logic [CMD_W-1:0] CMD_FOCUS_FAR    = 5'd13;
	localparam logic [CMD_W-1:0] CMD_FOCUS_NEAR   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_STOP         = 5'd15;
	localparam logic [CMD_W-1:0] CMD_LIGHT_ON     = 5'd16;
	localparam logic [CMD_W-1:0] CMD_LIGHT_OFF    = 5'd17;
	localparam logic [CMD_W-1:0] CMD_WIPER_ON     = 5'd18;
	localparam logic [CMD_W-1:0] CMD_WIPER_OFF    = 5'd19;
	localparam logic [CMD_W-1:0] CMD_POWER_ON     = 5'd20;
	localparam logic [CMD_W-1:0] CMD_POWER_OFF    = 5'd21;
	localparam logic [CMD_W-1:0] CMD_GOTO_PRESET  = 5'd22;
	localparam logic [CMD_W-1:0] CMD_SET_PRESET   = 5'd23;
	localparam logic [CMD_W-1:0] CMD_CLEAR_PRESET = 5'd24;

	// Frame byte positions
	localparam logic [2:0] IDX_SYNC = 3'd0;
	localparam logic [2:0] IDX_ADDR = 3'd1;
	localparam logic [2:0] IDX_CMD1 = 3'd2;
	localparam logic [2:0] IDX_CMD2 = 3'd3;
	localparam logic [2:0] IDX_PAN  = 3'd4;
	localparam logic [2:0] IDX_TILT = 3'd5;
	localparam logic [2:0] IDX_CSUM = 3'd6;

	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] SPEED_1      = 8'h10;
	localparam logic [7:0] SPEED_2      = 8'h1A;
	localparam logic [7:0] SPEED_3      = 8'h24;
	localparam logic [7:0] SPEED_4      = 8'h30;
	localparam logic [7:0] SPEED_5      = 8'h3C;
	localparam logic [7:0] NORMAL_SPEED = SPEED_3;

	typedef enum logic [1:0] {
		SRC_LIT = 2'd0,
		SRC_SPD = 2'd1,
		SRC_ARG = 2'd2
	} byte_src_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
		byte_src_t  pan_src;
		logic [7:0] pan_lit;
		byte_src_t  tilt_src;
		logic [7:0] tilt_lit;
	} cmd_entry_t;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
		logic [7:0] pan;
		logic [7:0] tilt;
		logic [7:0] csum;
	} frame_rec_t;

	function automatic cmd_entry_t mk_entry(logic [7:0] c1, logic [7:0] c2,
			byte_src_t ps, logic [7:0] pl, byte_src_t ts, logic [7:0] tl);
		cmd_entry_t e;
		e.valid    = 1'b1;
		e.cmd1     = c1;
		e.cmd2     = c2;
		e.pan_src  = ps;
		e.pan_lit  = pl;
		e.tilt_src = ts;
		e.tilt_lit = tl;
		return e;
	endfunction

	function automatic cmd_entry_t cmd_lookup(logic [CMD_W-1:0] cmd);
		cmd_entry_t e;
		case (cmd)
			CMD_UP:           e = mk_entry(8'h00, 8'h08, SRC_LIT, 8'h00, SRC_SPD, 8'h00);
			CMD_DOWN:         e = mk_entry(8'h00, 8'h10, SRC_LIT, 8'h00, SRC_SPD, 8'h00);
			CMD_LEFT:         e = mk_entry(8'h00, 8'h04, SRC_SPD, 8'h00, SRC_LIT, 8'h00);
			CMD_RIGHT:        e = mk_entry(8'h00, 8'h02, SRC_SPD, 8'h00, SRC_LIT, 8'h00);
			CMD_LEFT_UP:      e = mk_entry(8'h00, 8'h0C, SRC_SPD, 8'h00, SRC_SPD, 8'h00);
			CMD_RIGHT_UP:     e = mk_entry(8'h00, 8'h0A, SRC_SPD, 8'h00, SRC_SPD, 8'h00);
			CMD_LEFT_DOWN:    e = mk_entry(8'h00, 8'h14, SRC_SPD, 8'h00, SRC_SPD, 8'h00);
			CMD_RIGHT_DOWN:   e = mk_entry(8'h00, 8'h12, SRC_SPD, 8'h00, SRC_SPD, 8'h00);
			CMD_AUTOPAN:      e = mk_entry(8'h90, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_IRIS_OPEN:    e = mk_entry(8'h02, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_IRIS_CLOSE:   e = mk_entry(8'h04, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_ZOOM_IN:      e = mk_entry(8'h00, 8'h20, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_ZOOM_OUT:     e = mk_entry(8'h00, 8'h40, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_FOCUS_FAR:    e = mk_entry(8'h00, 8'h80, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_FOCUS_NEAR:   e = mk_entry(8'h01, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_STOP:         e = mk_entry(8'h00, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
			CMD_LIGHT_ON:     e = mk_entry(8'h00, 8'h09, SRC_LIT, 8'h00, SRC_LIT, 8'h01);
			CMD_LIGHT_OFF:    e = mk_entry(8'h00, 8'h0B, SRC_LIT, 8'h00, SRC_LIT, 8'h01);
			CMD_WIPER_ON:     e = mk_entry(8'h00, 8'h09, SRC_LIT, 8'h00, SRC_LIT, 8'h02);
			CMD_WIPER_OFF:    e = mk_entry(8'h00, 8'h0B, SRC_LIT, 8'h00, SRC_LIT, 8'h02);
			CMD_POWER_ON:     e = mk_entry(8'h00, 8'h09, SRC_LIT, 8'h00, SRC_LIT, 8'h04);
			CMD_POWER_OFF:    e = mk_entry(8'h00, 8'h0B, SRC_LIT, 8'h00, SRC_LIT, 8'h04);
			CMD_GOTO_PRESET:  e = mk_entry(8'h00, 8'h07, SRC_LIT, 8'h00, SRC_ARG, 8'h00);
			CMD_SET_PRESET:   e = mk_entry(8'h00, 8'h03, SRC_LIT, 8'h00, SRC_ARG, 8'h00);
			CMD_CLEAR_PRESET: e = mk_entry(8'h00, 8'h05, SRC_LIT, 8'h00, SRC_ARG, 8'h00);
			default: begin
				e       = mk_entry(8'h00, 8'h00, SRC_LIT, 8'h00, SRC_LIT, 8'h00);
				e.valid = 1'b0;
			end
		endcase
		return e;
	endfunction

	function automatic logic [7:0] level_speed(logic [7:0] lvl);
		logic [7:0] s;
		case (lvl)
			8'd1:    s = SPEED_1;
			8'd2:    s = SPEED_2;
			8'd3:    s = SPEED_3;
			8'd4:    s = SPEED_4;
			8'd5:    s = SPEED_5;
			default: s = NORMAL_SPEED;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] resolve_byte(byte_src_t src, logic [7:0] lit,
			logic [7:0] arg);
		logic [7:0] b;
		case (src)
			SRC_SPD: b = level_speed(arg);
			SRC_ARG: b = arg;
			default: b = lit;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/ptzfb_front.sv =====
module ptzfb_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ptzfb_pkg::CMD_W-1:0]      command,
	input  logic [7:0]                       argument,
	input  logic [7:0]                       camera_address,
	output logic                             push_valid,
	input  logic                             push_ready,
	output ptzfb_pkg::frame_rec_t            push_rec
);
	import ptzfb_pkg::*;

	cmd_entry_t ent;
	frame_rec_t rec;
	logic       val_s1;
	frame_rec_t rec_s1;

	always_comb begin
		ent      = cmd_lookup(command);
		rec.addr = camera_address;
		rec.cmd1 = ent.cmd1;
		rec.cmd2 = ent.cmd2;
		rec.pan  = resolve_byte(ent.pan_src, ent.pan_lit, argument);
		rec.tilt = resolve_byte(ent.tilt_src, ent.tilt_lit, argument);
		rec.csum = rec.addr + rec.cmd1 + rec.cmd2 + rec.pan + rec.tilt;
	end

	// Stage frees up when empty or when the queue takes its word.
	assign in_ready   = !val_s1 || push_ready;
	assign push_valid = val_s1;
	assign push_rec   = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (in_ready) begin
			// drop unknown commands here
			val_s1 <= in_valid && ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rec_s1 <= rec;
		end
	end

endmodule

// ===== rtl/ptzfb_queue.sv =====
module ptzfb_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ptzfb_pkg::frame_rec_t push_rec,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ptzfb_pkg::frame_rec_t pop_rec
);
	import ptzfb_pkg::*;

	frame_rec_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_rec    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== rtl/ptzfb_back.sv =====
`include "ptz_command_frame_builder_macros.svh"

module ptzfb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ptzfb_pkg::frame_rec_t pop_rec,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            frame_byte,
	output logic                  last_byte
);
	import ptzfb_pkg::*;

	logic       active_q;
	logic [2:0] cnt_q;
	frame_rec_t rec_q;
	logic       fire;
	logic       at_last;

	assign at_last   = (cnt_q == IDX_CSUM);
	assign fire      = active_q && out_ready;
	assign out_valid = active_q;
	assign last_byte = at_last;
	// Load the next frame right behind the checksum word, no bubble.
	assign pop_ready = !active_q || (fire && at_last);

	always_comb begin
		case (cnt_q)
			IDX_SYNC: frame_byte = SYNC_BYTE;
			IDX_ADDR: frame_byte = rec_q.addr;
			IDX_CMD1: frame_byte = rec_q.cmd1;
			IDX_CMD2: frame_byte = rec_q.cmd2;
			IDX_PAN:  frame_byte = rec_q.pan;
			IDX_TILT: frame_byte = rec_q.tilt;
			IDX_CSUM: frame_byte = rec_q.csum;
			default:  frame_byte = SYNC_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= IDX_SYNC;
		end else if (pop_valid && pop_ready) begin
			active_q <= 1'b1;
			cnt_q    <= IDX_SYNC;
		end else if (fire && at_last) begin
			active_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			rec_q <= pop_rec;
		end
	end

	`PTZ_ASSERT_NOW(a_cnt_in_frame, clk, arst_n, active_q, cnt_q <= IDX_CSUM)
	`PTZ_ASSERT_NEXT(a_cnt_advance, clk, arst_n, fire && !at_last,
		active_q && (cnt_q == $past(cnt_q) + 3'd1))
	`PTZ_ASSERT_NEXT(a_idle_after_last, clk, arst_n, fire && at_last && !pop_valid,
		!active_q)
	`PTZ_ASSERT_NEXT(a_new_frame_starts_at_sync, clk, arst_n, pop_valid && pop_ready,
		active_q && (cnt_q == IDX_SYNC))

endmodule

// ===== rtl/ptz_command_frame_builder.sv =====
// Pan/tilt/zoom command frame builder. Each accepted request (command, argument,
// camera_address) becomes a seven-byte frame, sent one byte per accepted output
// word: sync 0xFF, address, command1, command2, pan speed, tilt speed, then the
// 8-bit sum of bytes 1 to 5 with last_byte high. Requests with an unknown command
// code (25 and up) are taken and yield no output. The front stage takes a request
// every cycle while the two-frame queue behind it has room; the serializer drains
// one byte per cycle while out_ready is high and sends frames back to back, so
// that serializer sets the sustained request rate. A request passes through the
// front stage register, a queue slot and the serializer's frame register before
// the first byte of its frame appears.
module ptz_command_frame_builder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ptzfb_pkg::CMD_W-1:0] command,
	input  logic [7:0]                  argument,
	input  logic [7:0]                  camera_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  frame_byte,
	output logic                        last_byte
);
	import ptzfb_pkg::*;

	logic       push_valid;
	logic       push_ready;
	frame_rec_t push_rec;
	logic       pop_valid;
	logic       pop_ready;
	frame_rec_t pop_rec;

	ptzfb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.argument       (argument),
		.camera_address (camera_address),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_rec       (push_rec)
	);

	ptzfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	ptzfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
